FILE: rtl/assert_macros.svh
// Assertion macros used by the slice index resolver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication, with the delay given by argument n; disabled while reset is active.
`define SIR_ASSERT_DLY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

FILE: rtl/sir_pkg.sv
// Types and constants of the slice index resolver.
`default_nettype none
package sir_pkg;

    localparam int INDEX_BITS = 32;
    localparam logic [31:0] IDX_MASK = (INDEX_BITS >= 32) ? 32'hFFFF_FFFF
                                     : 32'((64'd1 << INDEX_BITS) - 64'd1);
    localparam int DVD_W    = 35;
    localparam int DVS_W    = 32;
    localparam int PIPE_LAT = 3 + DVD_W + 1;

    typedef enum logic [1:0] {ST_OK, ST_OVER, ST_ZERO, ST_RANGE} t_status;
    typedef enum logic [1:0] {M_NONE, M_STEP, M_LEN} t_mode;

    typedef struct packed {
        logic [30:0]        dim_size;
        logic               has_begin;
        logic signed [31:0] begin_value;
        logic               has_end;
        logic signed [31:0] end_value;
        logic               has_length;
        logic [30:0]        length_value;
        logic               has_step;
        logic signed [31:0] step_value;
        logic               open_end;
    } t_in_item;

    typedef struct packed {
        logic [30:0]        slice_length;
        logic signed [31:0] slice_begin;
        logic signed [31:0] slice_step;
        logic [1:0]         status;
    } t_out_item;

    // Item state that rides along the divider pipeline.
    typedef struct packed {
        logic signed [63:0] beg;
        logic signed [63:0] fin;
        logic signed [31:0] step;
        logic [30:0]        len;
        logic [30:0]        size;
        t_status            status;
        t_mode              mode;
        logic               neg;
        logic               lenok;
    } t_side;

endpackage
`default_nettype wire

FILE: rtl/sir_prep.sv
// Front stages: index normalization, multiply, case resolution, divider setup.
`default_nettype none
module sir_prep (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire sir_pkg::t_in_item         i_item,
    output logic                           o_valid,
    output logic [sir_pkg::DVD_W-1:0]      o_dvd,
    output logic [sir_pkg::DVS_W-1:0]      o_dvs,
    output sir_pkg::t_side                 o_side
);

    typedef enum logic [1:0] {K_NONE, K_RATIO, K_CPOS, K_CNEG} t_kind;

    // ---- stage 1: normalize begin/end, form step * (length - 1)
    logic signed [63:0] n_beg1, n_end1, n_prod1, size64, bv64, ev64;
    logic [30:0]        n_lm1;

    always_comb begin
        size64 = {33'd0, i_item.dim_size};
        bv64   = {{32{i_item.begin_value[31]}}, i_item.begin_value};
        ev64   = {{32{i_item.end_value[31]}}, i_item.end_value};
        n_beg1 = 64'sd0;
        n_end1 = size64;
        if (i_item.has_begin) begin
            n_beg1 = i_item.begin_value[31] ? bv64 + size64 : bv64;
        end
        if (i_item.has_end) begin
            n_end1 = i_item.end_value[31] ? ev64 + size64 : ev64;
        end
        n_lm1   = i_item.length_value - 31'd1;
        n_prod1 = $signed(i_item.step_value) * $signed({1'b0, n_lm1});
    end

    logic               r1_vld;
    logic signed [63:0] r1_beg, r1_end, r1_prod;
    logic [30:0]        r1_lm1;
    sir_pkg::t_in_item  r1_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
        end
        r1_beg  <= n_beg1;
        r1_end  <= n_end1;
        r1_prod <= n_prod1;
        r1_lm1  <= n_lm1;
        r1_item <= i_item;
    end

    // ---- stage 2: pick the slice case, derive begin/end from the product
    logic signed [63:0] n_beg2, n_end2, dstep, lm1_64, r1_size64;
    logic signed [31:0] n_step2, s_eff;
    logic [30:0]        n_len2;
    sir_pkg::t_status   n_st2;
    t_kind              n_kind2;
    logic [31:0]        n_dvs2;
    logic signed [63:0] dpos_w, dneg_w;

    always_comb begin
        lm1_64    = {33'd0, r1_lm1};
        r1_size64 = {33'd0, r1_item.dim_size};
        dstep     = 64'sd0;
        if (r1_item.open_end) begin
            if (r1_item.step_value > 0) begin
                dstep = 64'sd1;
            end else if (r1_item.step_value < 0) begin
                dstep = -64'sd1;
            end
        end
        s_eff   = r1_item.has_step ? r1_item.step_value : 32'sd1;
        dpos_w  = r1_end - r1_beg;
        dneg_w  = r1_beg - r1_end;
        n_beg2  = r1_beg;
        n_end2  = r1_end;
        n_step2 = 32'sd1;
        n_len2  = 31'd0;
        n_st2   = sir_pkg::ST_OK;
        n_kind2 = K_NONE;
        n_dvs2  = {1'b0, r1_lm1};
        if (r1_item.has_length) begin
            n_len2 = r1_item.length_value;
            if (r1_item.length_value != 31'd0) begin
                if (r1_item.has_step) begin
                    n_step2 = r1_item.step_value;
                    if (r1_item.has_begin && r1_item.has_end) begin
                        n_st2 = sir_pkg::ST_OVER;
                    end else if (r1_item.has_begin) begin
                        n_end2 = r1_beg + r1_prod;
                    end else if (r1_item.has_end) begin
                        n_end2 = r1_end - dstep;
                        n_beg2 = r1_end - dstep - r1_prod;
                    end else begin
                        n_beg2 = 64'sd0;
                        n_end2 = r1_prod;
                    end
                end else begin
                    if (r1_item.has_begin && r1_item.has_end) begin
                        n_kind2 = K_RATIO;
                    end else if (r1_item.has_begin) begin
                        n_end2 = r1_beg + lm1_64;
                    end else if (r1_item.has_end) begin
                        n_end2 = r1_end - {63'd0, r1_item.open_end};
                        n_beg2 = r1_end - {63'd0, r1_item.open_end} - lm1_64;
                    end else begin
                        n_beg2 = 64'sd0;
                        n_end2 = lm1_64;
                    end
                end
            end
        end else begin
            n_step2 = s_eff;
            if (s_eff > 0) begin
                n_end2  = r1_item.has_end ? r1_end - {63'd0, r1_item.open_end}
                                          : r1_size64 - 64'sd1;
                n_kind2 = K_CPOS;
                n_dvs2  = s_eff;
            end else if (s_eff < 0) begin
                n_beg2  = r1_item.has_begin ? r1_beg : r1_size64 - 64'sd1;
                n_end2  = r1_item.has_end ? r1_end + {63'd0, r1_item.open_end}
                                          : 64'sd0;
                n_kind2 = K_CNEG;
                n_dvs2  = 32'(-s_eff);
            end else begin
                n_st2 = sir_pkg::ST_ZERO;
            end
        end
    end

    logic               r2_vld, r2_ex;
    logic signed [63:0] r2_beg, r2_end;
    logic signed [35:0] r2_dpos, r2_dneg;
    logic signed [31:0] r2_step;
    logic [30:0]        r2_len, r2_size;
    sir_pkg::t_status   r2_st;
    t_kind              r2_kind;
    logic [31:0]        r2_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_ex   <= r1_item.open_end;
        r2_beg  <= n_beg2;
        r2_end  <= n_end2;
        r2_dpos <= dpos_w[35:0];
        r2_dneg <= dneg_w[35:0];
        r2_step <= n_step2;
        r2_len  <= n_len2;
        r2_size <= r1_item.dim_size;
        r2_st   <= n_st2;
        r2_kind <= n_kind2;
        r2_dvs  <= n_dvs2;
    end

    // ---- stage 3: exclusive-end trim and divider operands
    logic signed [35:0] mag0, mag;
    logic signed [63:0] diff, n_end3;
    logic [sir_pkg::DVD_W-1:0] n_dvd3;
    sir_pkg::t_mode     n_mode3;
    logic               n_neg3, n_lenok3;

    always_comb begin
        mag0     = r2_dpos[35] ? r2_dneg : r2_dpos;
        mag      = mag0;
        n_end3   = r2_end;
        diff     = (r2_kind == K_CNEG) ? r2_beg - r2_end : r2_end - r2_beg;
        n_dvd3   = '0;
        n_mode3  = sir_pkg::M_NONE;
        n_neg3   = 1'b0;
        n_lenok3 = 1'b0;
        case (r2_kind)
            K_RATIO: begin
                // pull the end one index toward the begin
                if (r2_ex && mag0 != 36'sd0) begin
                    mag    = mag0 - 36'sd1;
                    n_end3 = r2_dpos[35] ? r2_end + 64'sd1 : r2_end - 64'sd1;
                end
                n_neg3  = r2_dpos[35];
                n_dvd3  = mag[sir_pkg::DVD_W-1:0];
                n_mode3 = (r2_len > 31'd1) ? sir_pkg::M_STEP : sir_pkg::M_NONE;
            end
            K_CPOS, K_CNEG: begin
                n_lenok3 = !diff[63];
                n_dvd3   = diff[sir_pkg::DVD_W-1:0];
                n_mode3  = sir_pkg::M_LEN;
            end
            default: begin
                n_mode3 = sir_pkg::M_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r2_vld;
        end
        o_dvd        <= n_dvd3;
        o_dvs        <= r2_dvs;
        o_side.beg   <= r2_beg;
        o_side.fin   <= n_end3;
        o_side.step  <= r2_step;
        o_side.len   <= r2_len;
        o_side.size  <= r2_size;
        o_side.status <= r2_st;
        o_side.mode  <= n_mode3;
        o_side.neg   <= n_neg3;
        o_side.lenok <= n_lenok3;
    end

endmodule
`default_nettype wire

FILE: rtl/sir_div.sv
// Pipelined restoring divider, one quotient bit per stage, side data in step.
`default_nettype none
module sir_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [sir_pkg::DVD_W-1:0] i_dvd,
    input  wire logic [sir_pkg::DVS_W-1:0] i_dvs,
    input  wire sir_pkg::t_side            i_side,
    output logic                           o_valid,
    output logic [sir_pkg::DVD_W-1:0]      o_quo,
    output sir_pkg::t_side                 o_side
);

    localparam int N = sir_pkg::DVD_W;
    localparam int W = sir_pkg::DVS_W;

    logic           r_vld [N];
    logic [W-1:0]   r_rem [N];
    logic [N-1:0]   r_dvd [N];
    logic [N-1:0]   r_quo [N];
    logic [W-1:0]   r_dvs [N];
    sir_pkg::t_side r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic           p_vld;
        logic [W-1:0]   p_rem, p_dvs;
        logic [N-1:0]   p_dvd, p_quo;
        sir_pkg::t_side p_side;
        logic [W:0]     trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_dvd  = i_dvd;
            assign p_quo  = '0;
            assign p_dvs  = i_dvs;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_dvd  = r_dvd[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_dvs  = r_dvs[k-1];
            assign p_side = r_side[k-1];
        end

        assign trial = {p_rem, p_dvd[N-1]};
        assign ge    = trial >= {1'b0, p_dvs};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
            r_rem[k]  <= ge ? W'(trial - {1'b0, p_dvs}) : W'(trial);
            r_dvd[k]  <= {p_dvd[N-2:0], 1'b0};
            r_quo[k]  <= {p_quo[N-2:0], ge};
            r_dvs[k]  <= p_dvs;
            r_side[k] <= p_side;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quo   = r_quo[N-1];
    assign o_side  = r_side[N-1];

endmodule
`default_nettype wire

FILE: rtl/slice_index_resolver.sv
// Top level of the slice index resolver: front stages, divider, result stage.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------
//  command  | start (busy always 0)  | i_item  (sir_pkg::t_in_item)
//  result   | o_done, one cycle      | o_result (sir_pkg::t_out_item)
//
// One item enters every cycle; its result strobes once it has passed the three front
// stages, one stage per quotient bit of the 35-bit divider and one result stage.
// Synchronous active-low reset clears all valid bits; items in flight are dropped.
// Nothing stalls: the receiver takes each result as shown.
`default_nettype none
`include "assert_macros.svh"
module slice_index_resolver (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire sir_pkg::t_in_item  i_item,
    output logic                    o_done,
    output sir_pkg::t_out_item      o_result
);

    logic                      p_vld, d_vld;
    logic [sir_pkg::DVD_W-1:0] p_dvd, d_quo;
    logic [sir_pkg::DVS_W-1:0] p_dvs;
    sir_pkg::t_side            p_side, d_side;

    assign busy = 1'b0;

    sir_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_valid (p_vld),
        .o_dvd   (p_dvd),
        .o_dvs   (p_dvs),
        .o_side  (p_side)
    );

    sir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_vld),
        .i_dvd   (p_dvd),
        .i_dvs   (p_dvs),
        .i_side  (p_side),
        .o_valid (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    logic [sir_pkg::DVD_W-1:0] q_neg, q_inc;
    logic signed [31:0]        f_step;
    logic [30:0]               f_len;
    logic signed [63:0]        size64;
    logic                      out_of_range;
    sir_pkg::t_status          f_st;
    sir_pkg::t_out_item        n_result;

    always_comb begin
        q_neg  = -d_quo;
        q_inc  = d_quo + 1'b1;
        size64 = {33'd0, d_side.size};
        f_step = d_side.step;
        f_len  = d_side.len;
        case (d_side.mode)
            sir_pkg::M_STEP: f_step = d_side.neg ? q_neg[31:0] : d_quo[31:0];
            sir_pkg::M_LEN:  f_len  = d_side.lenok ? q_inc[30:0] : 31'd0;
            default:         f_len  = d_side.len;
        endcase
        out_of_range = d_side.beg < 0 || d_side.beg >= size64 ||
                       d_side.fin < 0 || d_side.fin >= size64;
        f_st = d_side.status;
        if (f_st == sir_pkg::ST_OK && out_of_range) begin
            f_st = sir_pkg::ST_RANGE;
        end
        n_result.status = f_st;
        if (f_st != sir_pkg::ST_OK) begin
            n_result.slice_length = '0;
            n_result.slice_begin  = '0;
            n_result.slice_step   = '0;
        end else begin
            n_result.slice_length = f_len;
            n_result.slice_begin  = d_side.beg[31:0] & sir_pkg::IDX_MASK;
            n_result.slice_step   = f_step & sir_pkg::IDX_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= d_vld;
        end
        o_result <= n_result;
    end

    `SIR_ASSERT_DLY(a_latency, start && !busy, sir_pkg::PIPE_LAT, o_done, "result strobe missing")
    `SIR_ASSERT_IMP(a_err_zero, o_done && o_result.status != sir_pkg::ST_OK,
        o_result.slice_length == 0 && o_result.slice_begin == 0 && o_result.slice_step == 0,
        "error result with nonzero fields")
    `SIR_ASSERT_IMP(a_div_flow, d_vld, $past(p_vld, sir_pkg::DVD_W), "divider lost an item")

endmodule
`default_nettype wire

FILE: dv/slice_index_resolver_tb.sv
// Testbench for the slice index resolver: directed table, random items, predicted results.
`timescale 1ns / 1ps
`default_nettype none
module slice_index_resolver_tb;

    localparam int LATENCY = sir_pkg::PIPE_LAT + 4;

    typedef struct {
        sir_pkg::t_in_item  item;
        logic               known;
        sir_pkg::t_out_item want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    sir_pkg::t_in_item  i_item;
    logic               o_done;
    sir_pkg::t_out_item o_result;

    sir_pkg::t_out_item pending_slices[$];
    int                 mismatch_count;
    t_row               dir_rows[$];

    slice_index_resolver u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predict the resolved slice with exact 64-bit index arithmetic.
    function automatic sir_pkg::t_out_item resolve_slice(sir_pkg::t_in_item it);
        longint             size;
        longint             bv;
        longint             ev;
        longint             sv;
        longint             beg;
        longint             fin;
        longint             step;
        longint             len;
        sir_pkg::t_status   st;
        sir_pkg::t_out_item r;
        size = longint'(it.dim_size);
        bv   = longint'(it.begin_value);
        ev   = longint'(it.end_value);
        sv   = longint'(it.step_value);
        beg  = 0;
        fin  = size;
        step = 1;
        len  = 0;
        st   = sir_pkg::ST_OK;
        if (it.has_begin) begin
            beg = bv;
            if (beg < 0) beg += size;
        end
        if (it.has_end) begin
            fin = ev;
            if (fin < 0) fin += size;
        end
        if (it.has_length) begin
            len = longint'(it.length_value);
            if (len > 0) begin
                if (it.has_step) begin
                    step = sv;
                    if (it.has_begin) begin
                        if (it.has_end) st = sir_pkg::ST_OVER;
                        else fin = beg + step * (len - 1);
                    end else if (it.has_end) begin
                        if (it.open_end) begin
                            if (step > 0) fin--;
                            if (step < 0) fin++;
                        end
                        beg = fin - step * (len - 1);
                    end else begin
                        beg = 0;
                        fin = step * (len - 1);
                    end
                end else begin
                    step = 1;
                    if (it.has_begin) begin
                        if (it.has_end) begin
                            if (it.open_end) begin
                                if (beg < fin) fin--;
                                else if (beg > fin) fin++;
                            end
                            if (len > 1) step = (fin - beg) / (len - 1);
                        end else begin
                            fin = beg + (len - 1);
                        end
                    end else if (it.has_end) begin
                        if (it.open_end) fin--;
                        beg = fin - (len - 1);
                    end else begin
                        beg = 0;
                        fin = len - 1;
                    end
                end
            end
        end else begin
            step = it.has_step ? sv : 1;
            if (step > 0) begin
                if (!it.has_begin) beg = 0;
                if (!it.has_end) fin = size - 1;
                else if (it.open_end) fin--;
                len = (beg <= fin) ? (fin - beg) / step + 1 : 0;
            end else if (step < 0) begin
                if (!it.has_begin) beg = size - 1;
                if (!it.has_end) fin = 0;
                else if (it.open_end) fin++;
                len = (beg >= fin) ? (beg - fin) / (-step) + 1 : 0;
            end else begin
                st = sir_pkg::ST_ZERO;
            end
        end
        if (st == sir_pkg::ST_OK && (beg < 0 || beg >= size || fin < 0 || fin >= size))
            st = sir_pkg::ST_RANGE;
        r = '0;
        r.status = st;
        if (st == sir_pkg::ST_OK) begin
            r.slice_length = len[30:0];
            r.slice_begin  = beg[31:0] & sir_pkg::IDX_MASK;
            r.slice_step   = step[31:0] & sir_pkg::IDX_MASK;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Results cannot be held off: check each one at the edge that ends its cycle.
    always @(posedge i_clk) begin
        sir_pkg::t_out_item w;
        if (i_rst_n && o_done) begin
            if (pending_slices.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_result.status), 64'd0);
            end else begin
                w = pending_slices.pop_front();
                if (o_result.slice_length !== w.slice_length)
                    report_mismatch("slice_length", 64'(o_result.slice_length),
                                    64'(w.slice_length));
                if (o_result.slice_begin !== w.slice_begin)
                    report_mismatch("slice_begin", 64'(o_result.slice_begin),
                                    64'(w.slice_begin));
                if (o_result.slice_step !== w.slice_step)
                    report_mismatch("slice_step", 64'(o_result.slice_step),
                                    64'(w.slice_step));
                if (o_result.status !== w.status)
                    report_mismatch("status", 64'(o_result.status), 64'(w.status));
            end
        end
    end

    function automatic sir_pkg::t_in_item mk(int size, bit hb, int bv, bit he, int ev,
                                             bit hl, int lv, bit hs, int sv, bit ex);
        sir_pkg::t_in_item it;
        it.dim_size     = 31'(size);
        it.has_begin    = hb;
        it.begin_value  = bv;
        it.has_end      = he;
        it.end_value    = ev;
        it.has_length   = hl;
        it.length_value = 31'(lv);
        it.has_step     = hs;
        it.step_value   = sv;
        it.open_end     = ex;
        return it;
    endfunction

    function automatic sir_pkg::t_out_item err_result(sir_pkg::t_status st);
        sir_pkg::t_out_item r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic void add_row(sir_pkg::t_in_item it, bit known, sir_pkg::t_status st);
        t_row row;
        row.item  = it;
        row.known = known;
        row.want  = err_result(st);
        dir_rows.push_back(row);
    endfunction

    function automatic int rand_index(int size);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6 && size > 0) return int'($urandom_range(0, size - 1));
        if (pick < 8 && size > 0) return -int'($urandom_range(1, size));
        return int'($urandom());
    endfunction

    // Mostly small sizes with in-range indexes; some raw noise for the far corners.
    function automatic sir_pkg::t_in_item random_item();
        sir_pkg::t_in_item it;
        int                size;
        logic [191:0]      raw;
        if ($urandom_range(0, 9) == 0) begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            it  = raw[$bits(sir_pkg::t_in_item)-1:0];
            return it;
        end
        case ($urandom_range(0, 3))
            0: size = $urandom_range(0, 4);
            1: size = $urandom_range(1, 64);
            2: size = $urandom_range(1, 100000);
            default: size = $urandom_range(1, 32'h7FFF_FFFF);
        endcase
        it.dim_size     = 31'(size);
        it.has_begin    = 1'($urandom_range(0, 1));
        it.begin_value  = rand_index(size);
        it.has_end      = 1'($urandom_range(0, 1));
        it.end_value    = rand_index(size);
        it.has_length   = 1'($urandom_range(0, 1));
        it.length_value = ($urandom_range(0, 7) == 0) ? 31'($urandom())
                                                      : 31'($urandom_range(0, 20));
        it.has_step     = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: it.step_value = 0;
            1: it.step_value = int'($urandom());
            2: it.step_value = -int'($urandom_range(1, 8));
            default: it.step_value = $urandom_range(1, 8);
        endcase
        it.open_end     = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_item(sir_pkg::t_in_item it, sir_pkg::t_out_item want);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_slices.push_back(want);
    endtask

    task automatic random_gap();
        int n;
        if ($urandom_range(0, 1) == 0) return;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        int idx;
        int wait_cycles;
        sir_pkg::t_in_item it;
        mismatch_count = 0;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;

        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, sir_pkg::ST_RANGE);
        add_row(mk(10, 1, 1, 1, 8, 1, 3, 1, 2, 0), 1, sir_pkg::ST_OVER);
        add_row(mk(10, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1, sir_pkg::ST_ZERO);
        add_row(mk(10, 1, 10, 0, 0, 0, 0, 0, 0, 0), 1, sir_pkg::ST_RANGE);
        add_row(mk(10, 1, -11, 0, 0, 0, 0, 0, 0, 0), 1, sir_pkg::ST_RANGE);
        add_row(mk(10, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, sir_pkg::ST_OK);
        add_row(mk(10, 1, -3, 1, -1, 0, 0, 0, 0, 1), 0, sir_pkg::ST_OK);
        add_row(mk(10, 0, 0, 0, 0, 0, 0, 1, -3, 0), 0, sir_pkg::ST_OK);
        add_row(mk(10, 1, 9, 1, 0, 0, 0, 1, -2, 1), 0, sir_pkg::ST_OK);
        add_row(mk(10, 1, 2, 0, 0, 1, 3, 1, 3, 0), 0, sir_pkg::ST_OK);
        add_row(mk(10, 0, 0, 1, 9, 1, 4, 1, 2, 1), 0, sir_pkg::ST_OK);
        add_row(mk(10, 0, 0, 1, 0, 1, 4, 1, -2, 1), 0, sir_pkg::ST_OK);
        add_row(mk(10, 0, 0, 0, 0, 1, 5, 1, 2, 0), 0, sir_pkg::ST_OK);
        add_row(mk(10, 1, 1, 1, 9, 1, 4, 0, 0, 1), 0, sir_pkg::ST_OK);
        add_row(mk(10, 1, 9, 1, 1, 1, 4, 0, 0, 1), 0, sir_pkg::ST_OK);
        add_row(mk(10, 1, 3, 0, 0, 1, 4, 0, 0, 0), 0, sir_pkg::ST_OK);
        add_row(mk(10, 0, 0, 1, 8, 1, 4, 0, 0, 1), 0, sir_pkg::ST_OK);
        add_row(mk(10, 0, 0, 0, 0, 1, 6, 0, 0, 0), 0, sir_pkg::ST_OK);
        add_row(mk(10, 1, 4, 1, 7, 1, 0, 1, 5, 0), 0, sir_pkg::ST_OK);
        add_row(mk(10, 1, 0, 0, 0, 1, 3, 1, 0, 0), 0, sir_pkg::ST_OK);
        add_row(mk(32'h7FFF_FFFF, 1, 32'h7FFF_FFFE, 1, 32'h8000_0000, 0, 0, 1,
                   32'h8000_0000, 0), 0, sir_pkg::ST_OK);
        add_row(mk(32'h7FFF_FFFF, 1, 0, 1, 32'h7FFF_FFFE, 1, 32'h7FFF_FFFF, 0, 0, 0),
                0, sir_pkg::ST_OK);
        add_row(mk(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF, 1), 0,
                sir_pkg::ST_OK);
        add_row(mk(5, 1, 0, 0, 0, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0), 0,
                sir_pkg::ST_OK);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            it = dir_rows[r].item;
            send_item(it, dir_rows[r].known ? dir_rows[r].want : resolve_slice(it));
            random_gap();
        end

        for (idx = 0; idx < 1450; idx++) begin
            it = random_item();
            send_item(it, resolve_slice(it));
            // Let the pipeline drain completely once mid-run.
            if (idx == 700) begin
                start <= 1'b0;
                while (pending_slices.size() != 0) @(posedge i_clk);
            end else if (idx > 300 && idx < 500) begin
                // Back-to-back stretch: no gaps.
            end else begin
                random_gap();
            end
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_slices.size() != 0 && wait_cycles < 10 * LATENCY) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY) @(posedge i_clk);

        if (mismatch_count == 0 && pending_slices.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            if (pending_slices.size() != 0)
                $display("%0d results never arrived", pending_slices.size());
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/sir_pkg.sv
rtl/sir_prep.sv
rtl/sir_div.sv
rtl/slice_index_resolver.sv
dv/slice_index_resolver_tb.sv
